### rtl/tut_pkg.sv
// Shared constants and types for the timer-tick UART transceiver.
package tut_pkg;

	localparam int unsigned BitPeriodW = 16;
	localparam int unsigned RxCountW = BitPeriodW + 1;
	localparam int unsigned FrameW = 10;
	localparam int unsigned DataW = 8;
	localparam int unsigned BitsLeftW = 4;

	localparam logic [BitPeriodW-1:0] BitPeriodReset = 16'd104;
	localparam logic [BitsLeftW-1:0] FrameBits = 4'd10;
	localparam logic [BitsLeftW-1:0] DataBits = 4'd8;

	// Register index of bit_period on the configuration port.
	localparam logic RegBitPeriod = 1'b0;

	typedef struct packed {
		logic line;
		logic busy;
	} tx_res_t;

	typedef struct packed {
		logic valid;
		logic [DataW-1:0] data;
	} rx_res_t;

endpackage

### rtl/tut_tx.sv
// Transmitter: 8N1 frame sequencer, one tick per step.
module tut_tx import tut_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  logic                  start,
	input  logic [DataW-1:0]      data,
	input  logic [BitPeriodW-1:0] bit_period,
	output tx_res_t               res
);

	logic [FrameW-1:0]     shift_q, shift_d;
	logic [BitsLeftW-1:0]  bits_left_q, bits_left_d;
	logic                  active_q, active_d;
	logic [BitPeriodW-1:0] tick_q, tick_d;
	logic                  next_level_q, next_level_d;
	logic                  level_q, level_d;

	always_comb begin
		shift_d = shift_q;
		bits_left_d = bits_left_q;
		active_d = active_q;
		tick_d = tick_q;
		next_level_d = next_level_q;
		level_d = level_q;

		if (active_q) begin
			if (tick_q <= BitPeriodW'(1)) begin
				tick_d = bit_period;
				level_d = next_level_q;
				if (bits_left_q == '0) begin
					active_d = 1'b0;
					bits_left_d = FrameBits;
				end else begin
					next_level_d = shift_q[0];
					shift_d = {1'b0, shift_q[FrameW-1:1]};
					bits_left_d = bits_left_q - BitsLeftW'(1);
				end
			end else begin
				tick_d = tick_q - BitPeriodW'(1);
			end
		end

		// New request: frame is {stop, data, start}; start bit is scheduled at once.
		if (!active_d && start) begin
			active_d = 1'b1;
			tick_d = bit_period;
			next_level_d = 1'b0;
			shift_d = {1'b0, 1'b1, data};
			bits_left_d = FrameBits - BitsLeftW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q <= '0;
			bits_left_q <= FrameBits;
			active_q <= 1'b0;
			tick_q <= '0;
			next_level_q <= 1'b1;
			level_q <= 1'b1;
		end else if (step) begin
			shift_q <= shift_d;
			bits_left_q <= bits_left_d;
			active_q <= active_d;
			tick_q <= tick_d;
			next_level_q <= next_level_d;
			level_q <= level_d;
		end
	end

	assign res.line = level_d;
	assign res.busy = active_d;

endmodule

### rtl/tut_rx.sv
// Receiver: falling-edge start detect and mid-bit sampling of 8 data bits.
module tut_rx import tut_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  logic                  line,
	input  logic [BitPeriodW-1:0] bit_period,
	output rx_res_t               res
);

	logic                 active_q, active_d;
	logic [RxCountW-1:0]  tick_q, tick_d;
	logic [DataW-1:0]     shift_q, shift_d;
	logic [BitsLeftW-1:0] bits_left_q, bits_left_d;
	logic                 prev_q;
	logic [DataW-1:0]     last_q, last_d;
	logic                 valid;

	always_comb begin
		active_d = active_q;
		tick_d = tick_q;
		shift_d = shift_q;
		bits_left_d = bits_left_q;
		last_d = last_q;
		valid = 1'b0;

		if (active_q) begin
			if (tick_q <= RxCountW'(1)) begin
				shift_d = {line, shift_q[DataW-1:1]};
				bits_left_d = bits_left_q - BitsLeftW'(1);
				if (bits_left_d == '0) begin
					last_d = shift_d;
					valid = 1'b1;
					active_d = 1'b0;
					bits_left_d = DataBits;
				end else begin
					tick_d = RxCountW'(bit_period);
				end
			end else begin
				tick_d = tick_q - RxCountW'(1);
			end
		end else if (prev_q && !line) begin
			// First sample lands 1.5 bit periods after the edge.
			active_d = 1'b1;
			bits_left_d = DataBits;
			tick_d = RxCountW'(bit_period) + RxCountW'(bit_period >> 1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			tick_q <= '0;
			shift_q <= '0;
			bits_left_q <= DataBits;
			prev_q <= 1'b1;
			last_q <= '0;
		end else if (step) begin
			active_q <= active_d;
			tick_q <= tick_d;
			shift_q <= shift_d;
			bits_left_q <= bits_left_d;
			prev_q <= line;
			last_q <= last_d;
		end
	end

	assign res.valid = valid;
	assign res.data = last_d;

endmodule

### rtl/timer_uart_transceiver.sv
// Top level of the timer-tick 8N1 UART transceiver.
//
// Every request on the input stream is one timer tick: the sampled receive
// level plus an optional byte to send. Each tick yields exactly one output
// request with the transmit level, busy flag, received-byte pulse and the
// last received byte. A tick is processed combinationally by the transmitter
// and receiver next-state logic and lands in an output register, so one tick
// is taken per clock while the output side keeps up; the input stalls only
// while that output register holds a request not yet taken.
// bit_period (ticks per serial bit, reset 104) is written through the APB
// port at address 0 and applies at the next counter reload.
module timer_uart_transceiver import tut_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// APB configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// input ticks
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,  // [0] rx_line, [1] tx_start, [9:2] tx_byte, [15:10] zero
	// output results
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata   // [0] tx_line, [1] tx_busy, [2] rx_valid, [10:3] rx_byte
);

	logic [BitPeriodW-1:0] bit_period_q;
	logic                  step;
	tx_res_t               tx_res;
	rx_res_t               rx_res;
	logic                  m_tvalid_q;
	logic [15:0]           m_tdata_q;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == RegBitPeriod) ? {16'd0, bit_period_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_period_q <= BitPeriodReset;
		end else if (psel && penable && pwrite && pready && paddr[2] == RegBitPeriod) begin
			bit_period_q <= pwdata[BitPeriodW-1:0];
		end
	end

	assign s_tready = !m_tvalid_q || m_tready;
	assign step = s_tvalid && s_tready;

	tut_tx u_tx (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (step),
		.start      (s_tdata[1]),
		.data       (s_tdata[9:2]),
		.bit_period (bit_period_q),
		.res        (tx_res)
	);

	tut_rx u_rx (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (step),
		.line       (s_tdata[0]),
		.bit_period (bit_period_q),
		.res        (rx_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (s_tready) begin
			m_tvalid_q <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			m_tdata_q <= {5'd0, rx_res.data, rx_res.valid, tx_res.busy, tx_res.line};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata = m_tdata_q;

endmodule

### dv/timer_uart_transceiver_tb.sv
// Self-checking testbench for the timer-tick 8N1 UART transceiver.
module timer_uart_transceiver_tb import tut_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned UnmappedReg = 1;  // register index with nothing behind it
	localparam int unsigned StallLimit = 5000;
	localparam int unsigned PhaseTicks = 150;
	localparam int unsigned NumPhases = 12;
	localparam int unsigned PressurePhase = 5;
	localparam int unsigned HoldCycles = 400;
	localparam int unsigned PhasePeriods [NumPhases] =
		'{2, 0, 1, 3, 65535, 4, 7, 104, 2, 5, 9, 16};

	typedef struct packed {
		logic       tx_line;
		logic       tx_busy;
		logic       rx_valid;
		logic [7:0] rx_byte;
	} uart_out_t;

	typedef struct packed {
		logic       rx_line;
		logic       tx_start;
		logic [7:0] tx_data;
		logic       has_fixed;
		uart_out_t  fixed_out;
	} tick_t;

	typedef struct {
		logic [9:0]  tx_shift;
		logic [3:0]  tx_left;
		logic        tx_on;
		logic [15:0] tx_cnt;
		logic        tx_next;
		logic        tx_lvl;
		logic        rx_on;
		logic [16:0] rx_cnt;
		logic [7:0]  rx_shift;
		logic [3:0]  rx_left;
		logic        rx_prev;
		logic [7:0]  rx_byte;
	} uart_state_t;

	localparam uart_out_t NoOut = '0;

	// bit_period 2: one send accepted at once, a request while busy, a received 0xA5,
	// and a new send on the tick the stop bit begins.
	localparam tick_t DirRows [24] = '{
		'{1'b1, 1'b0, 8'h00, 1'b1, '{1'b1, 1'b0, 1'b0, 8'h00}},
		'{1'b1, 1'b1, 8'hFF, 1'b1, '{1'b1, 1'b1, 1'b0, 8'h00}},
		'{1'b0, 1'b1, 8'h00, 1'b0, NoOut},
		'{1'b0, 1'b0, 8'h5A, 1'b0, NoOut},
		'{1'b1, 1'b0, 8'h5A, 1'b0, NoOut},
		'{1'b1, 1'b0, 8'h5A, 1'b0, NoOut},
		'{1'b0, 1'b0, 8'h5A, 1'b0, NoOut},
		'{1'b0, 1'b0, 8'h5A, 1'b0, NoOut},
		'{1'b1, 1'b0, 8'h5A, 1'b0, NoOut},
		'{1'b1, 1'b0, 8'h5A, 1'b0, NoOut},
		'{1'b0, 1'b0, 8'h5A, 1'b0, NoOut},
		'{1'b0, 1'b0, 8'h5A, 1'b0, NoOut},
		'{1'b0, 1'b0, 8'h5A, 1'b0, NoOut},
		'{1'b0, 1'b0, 8'h5A, 1'b0, NoOut},
		'{1'b1, 1'b0, 8'h5A, 1'b0, NoOut},
		'{1'b1, 1'b0, 8'h5A, 1'b0, NoOut},
		'{1'b0, 1'b0, 8'h5A, 1'b0, NoOut},
		'{1'b0, 1'b0, 8'h5A, 1'b0, NoOut},
		'{1'b1, 1'b0, 8'h5A, 1'b0, NoOut},
		'{1'b1, 1'b0, 8'h5A, 1'b0, NoOut},
		'{1'b1, 1'b1, 8'h3C, 1'b0, NoOut},
		'{1'b1, 1'b1, 8'h00, 1'b0, NoOut},
		'{1'b1, 1'b0, 8'hA5, 1'b0, NoOut},
		'{1'b0, 1'b0, 8'hFF, 1'b0, NoOut}
	};

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        s_tvalid;
	logic        s_tready;
	logic [15:0] s_tdata;  // [0] rx_line, [1] tx_start, [9:2] tx_byte, [15:10] zero
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;  // [0] tx_line, [1] tx_busy, [2] rx_valid, [10:3] rx_byte

	uart_state_t      uart_st;
	logic [15:0]      bit_period;
	tick_t            tick_q [$];
	tick_t            cur_tick;
	uart_out_t        awaited_outputs [$];
	int unsigned      errors;
	int unsigned      quiet_cycles;
	int unsigned      send_idle_pct;
	int unsigned      stall_pct;
	bit               hold_req;

	timer_uart_transceiver DUT (.*);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic void tx_take_bit();
		uart_st.tx_next = uart_st.tx_shift[0];
		uart_st.tx_shift = uart_st.tx_shift >> 1;
		uart_st.tx_left = uart_st.tx_left - 4'd1;
	endfunction

	// One timer tick of the transceiver; returns the outputs after the tick.
	function automatic uart_out_t uart_tick(logic line, logic start, logic [7:0] data);
		logic valid;
		valid = 1'b0;
		if (uart_st.tx_on) begin
			if (uart_st.tx_cnt <= 16'd1) begin
				uart_st.tx_cnt = bit_period;
				uart_st.tx_lvl = uart_st.tx_next;
				if (uart_st.tx_left == 4'd0) begin
					uart_st.tx_on = 1'b0;
					uart_st.tx_left = FrameBits;
				end else begin
					tx_take_bit();
				end
			end else begin
				uart_st.tx_cnt = uart_st.tx_cnt - 16'd1;
			end
		end
		if (!uart_st.tx_on && start) begin
			uart_st.tx_shift = {1'b1, data, 1'b0};
			uart_st.tx_left = FrameBits;
			uart_st.tx_on = 1'b1;
			uart_st.tx_cnt = bit_period;
			tx_take_bit();
		end
		if (uart_st.rx_on) begin
			if (uart_st.rx_cnt <= 17'd1) begin
				uart_st.rx_shift = {line, uart_st.rx_shift[7:1]};
				uart_st.rx_left = uart_st.rx_left - 4'd1;
				if (uart_st.rx_left == 4'd0) begin
					uart_st.rx_byte = uart_st.rx_shift;
					valid = 1'b1;
					uart_st.rx_on = 1'b0;
					uart_st.rx_left = DataBits;
				end else begin
					uart_st.rx_cnt = {1'b0, bit_period};
				end
			end else begin
				uart_st.rx_cnt = uart_st.rx_cnt - 17'd1;
			end
		end else if (uart_st.rx_prev && !line) begin
			uart_st.rx_on = 1'b1;
			uart_st.rx_left = DataBits;
			// first sample lands mid-way into data bit 0
			uart_st.rx_cnt = {1'b0, bit_period} + {2'b00, bit_period[15:1]};
		end
		uart_st.rx_prev = line;
		return '{uart_st.tx_lvl, uart_st.tx_on, valid, uart_st.rx_byte};
	endfunction

	function automatic void queue_tick(logic line);
		tick_t t;
		t.rx_line = line;
		t.tx_start = ($urandom_range(15) == 0);
		t.tx_data = 8'($urandom);
		t.has_fixed = 1'b0;
		t.fixed_out = NoOut;
		tick_q.push_back(t);
	endfunction

	// Mostly clean 8N1 frames at the current rate, some with a ragged bit, the rest noise.
	task automatic build_random_ticks(input int unsigned n);
		int unsigned blen;
		int unsigned len;
		int unsigned j;
		int b;
		logic [9:0] frame;
		blen = (bit_period < 16'd1) ? 1 : bit_period;
		while (tick_q.size() < n) begin
			if ($urandom_range(9) < 8) begin
				len = $urandom_range(blen, 1);
				for (j = 0; j < len && tick_q.size() < n; j++)
					queue_tick(1'b1);
				frame = {1'b1, 8'($urandom), 1'b0};
				for (b = 0; b < 10; b++) begin
					len = blen;
					if ($urandom_range(9) == 0)
						len = blen + $urandom_range(2) - 1;
					if (len == 0)
						len = 1;
					for (j = 0; j < len && tick_q.size() < n; j++)
						queue_tick(frame[b]);
				end
			end else begin
				len = $urandom_range(2 * blen, 1);
				for (j = 0; j < len && tick_q.size() < n; j++)
					queue_tick(1'($urandom));
			end
		end
	endtask

	// Offers every queued tick; starts and ends on a falling edge.
	task automatic drive_ticks();
		while (tick_q.size() != 0) begin
			while ($urandom_range(99) < send_idle_pct) begin
				s_tvalid <= 1'b0;
				@(negedge clk);
			end
			s_tvalid <= 1'b1;
			cur_tick <= tick_q[0];
			s_tdata <= {6'd0, tick_q[0].tx_data, tick_q[0].tx_start, tick_q[0].rx_line};
			@(posedge clk);
			while (!s_tready)
				@(posedge clk);
			void'(tick_q.pop_front());
			@(negedge clk);
		end
		s_tvalid <= 1'b0;
	endtask

	task automatic apb_write(input int unsigned idx, input logic [31:0] val);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= 3'(idx * 4);
		pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (idx == RegBitPeriod)
			bit_period = val[15:0];
	endtask

	task automatic verify_bit_period();
		logic [31:0] rd;
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= {RegBitPeriod, 2'b00};
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		rd = prdata;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		if (rd != {16'd0, bit_period}) begin
			$error("bit_period: expected %0d, got %0d", bit_period, rd);
			errors++;
		end
	endtask

	task automatic drain();
		wait (awaited_outputs.size() == 0);
		repeat (4) @(negedge clk);
	endtask

	// Output side: random stalls, plus one long hold-off on request.
	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				repeat (HoldCycles) begin
					m_tready <= 1'b0;
					@(negedge clk);
				end
			end
			m_tready <= ($urandom_range(99) >= stall_pct);
		end
	end

	always @(posedge clk) begin
		uart_out_t want;
		uart_out_t got;
		uart_out_t pred;
		if (arst_n) begin
			// compare before pushing: this edge's request cannot be on the output yet
			if (m_tvalid && m_tready) begin
				got = '{m_tdata[0], m_tdata[1], m_tdata[2], m_tdata[10:3]};
				if (awaited_outputs.size() == 0) begin
					$error("unexpected output request %h", m_tdata);
					errors++;
				end else begin
					want = awaited_outputs.pop_front();
					if (got.tx_line !== want.tx_line) begin
						$error("tx_line: expected %0d, got %0d", want.tx_line, got.tx_line);
						errors++;
					end
					if (got.tx_busy !== want.tx_busy) begin
						$error("tx_busy: expected %0d, got %0d", want.tx_busy, got.tx_busy);
						errors++;
					end
					if (got.rx_valid !== want.rx_valid) begin
						$error("rx_valid: expected %0d, got %0d", want.rx_valid,
							got.rx_valid);
						errors++;
					end
					if (got.rx_byte !== want.rx_byte) begin
						$error("rx_byte: expected %h, got %h", want.rx_byte, got.rx_byte);
						errors++;
					end
				end
			end
			if (s_tvalid && s_tready) begin
				pred = uart_tick(cur_tick.rx_line, cur_tick.tx_start, cur_tick.tx_data);
				awaited_outputs.push_back(cur_tick.has_fixed ? cur_tick.fixed_out : pred);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= StallLimit) begin
				$display("FAILED: results differ");
				$finish;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		cur_tick = '0;
		errors = 0;
		quiet_cycles = 0;
		send_idle_pct = 0;
		stall_pct = 0;
		hold_req = 1'b0;
		bit_period = BitPeriodReset;
		uart_st = '{tx_shift: '0, tx_left: FrameBits, tx_on: 1'b0, tx_cnt: '0,
			tx_next: 1'b1, tx_lvl: 1'b1, rx_on: 1'b0, rx_cnt: '0, rx_shift: '0,
			rx_left: DataBits, rx_prev: 1'b1, rx_byte: '0};
		repeat (12) @(negedge clk);
		arst_n = 1'b1;

		verify_bit_period();
		apb_write(RegBitPeriod, 32'd2);
		apb_write(UnmappedReg, $urandom);
		verify_bit_period();

		foreach (DirRows[i])
			tick_q.push_back(DirRows[i]);
		drive_ticks();
		drain();

		for (int ph = 0; ph < NumPhases; ph++) begin
			apb_write(RegBitPeriod, PhasePeriods[ph]);
			verify_bit_period();
			case (ph % 4)
				0: begin send_idle_pct = 0; stall_pct = 0; end
				1: begin send_idle_pct = 85; stall_pct = 0; end
				2: begin send_idle_pct = 0; stall_pct = 85; end
				default: begin send_idle_pct = 16; stall_pct = 16; end
			endcase
			if (ph == PressurePhase) begin
				// sender keeps offering while the output side is held off
				send_idle_pct = 0;
				stall_pct = 0;
				hold_req = 1'b1;
			end
			build_random_ticks(PhaseTicks);
			drive_ticks();
			drain();
		end

		repeat (20) @(posedge clk);
		if (errors == 0 && awaited_outputs.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
